@@ hw/rtl/tchs_pkg.sv @@
// ----------------------------------------------------------------------------
// tchs_pkg
// Shared types, codes and the version pick for the client hello sniffer.
// ----------------------------------------------------------------------------
package tchs_pkg;

    localparam int NUM_BYTES = 11;

    // disable mask bits
    localparam int MSK_V2  = 0;
    localparam int MSK_V3  = 1;
    localparam int MSK_T10 = 2;
    localparam int MSK_T11 = 3;
    localparam int MSK_T12 = 4;

    // selected protocol version
    localparam logic [1:0] VER_S30 = 2'd0;
    localparam logic [1:0] VER_T10 = 2'd1;
    localparam logic [1:0] VER_T11 = 2'd2;
    localparam logic [1:0] VER_T12 = 2'd3;

    // verdict codes
    localparam logic [2:0] VERDICT_RECORD      = 3'd0;
    localparam logic [2:0] VERDICT_V2_HELLO    = 3'd1;
    localparam logic [2:0] VERDICT_UNSUPPORTED = 3'd2;
    localparam logic [2:0] VERDICT_UNKNOWN     = 3'd3;
    localparam logic [2:0] VERDICT_HTTP        = 3'd4;
    localparam logic [2:0] VERDICT_PROXY       = 3'd5;
    localparam logic [2:0] VERDICT_TOO_LARGE   = 3'd6;

    // header kind found by the decode stage
    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_V2_ONLY = 3'd1;
    localparam logic [2:0] KIND_V2_WRAP = 3'd2;
    localparam logic [2:0] KIND_RECORD  = 3'd3;
    localparam logic [2:0] KIND_HTTP    = 3'd4;
    localparam logic [2:0] KIND_PROXY   = 3'd5;

    localparam logic [7:0]  REC_HANDSHAKE = 8'h16;
    localparam logic [7:0]  MINOR_MAX     = 8'hff;
    localparam logic [14:0] V2_LIMIT      = 15'(1024 * 4);

    localparam logic [31:0] TXT_GET  = "GET ";
    localparam logic [39:0] TXT_POST = "POST ";
    localparam logic [39:0] TXT_HEAD = "HEAD ";
    localparam logic [31:0] TXT_PUT  = "PUT ";
    localparam logic [55:0] TXT_CONN = "CONNECT";

    typedef logic [NUM_BYTES-1:0][7:0] hdr_bytes_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  minor;
        logic [14:0] blen;
        logic [4:0]  mask;
    } dec_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  minor;
        logic [14:0] blen;
        logic        v2_off;
        logic        got;
        logic [1:0]  ver;
        logic        too_large;
    } sel_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [1:0]  ver;
        logic [7:0]  minor;
        logic [14:0] blen;
    } res_t;

    // highest enabled version for a nonzero client minor; bit 2 flags a hit
    function automatic logic [2:0] pick_tls(input logic [7:0] minor, input logic [4:0] msk);
        logic [2:0] r;
        if (minor >= 8'd3 && !msk[MSK_T12]) begin
            r = {1'b1, VER_T12};
        end else if (minor >= 8'd2 && !msk[MSK_T11]) begin
            r = {1'b1, VER_T11};
        end else if (!msk[MSK_T10]) begin
            r = {1'b1, VER_T10};
        end else if (!msk[MSK_V3]) begin
            r = {1'b1, VER_S30};
        end else begin
            r = {1'b0, VER_S30};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/tls_client_hello_sniffer.sv @@
// ----------------------------------------------------------------------------
// tls_client_hello_sniffer
// Classifies the first 11 bytes of a connection: SSLv2-framed hello,
// TLS-record ClientHello, or HTTP / proxy request.
//
// Usage:
//   s_* carries one header item (bytes 0..10) under valid/ready; m_* returns
//   one result item per header: verdict, selected version, client minor and
//   v2 body length. cfg_wr_en/cfg_wr_data write the 5-bit disable mask
//   (reset value 0); write it only while no item is in flight.
//   Items pass through the decode, version select and verdict register stages
//   on the way to m_valid. Throughput is one item per cycle while m_ready is high.
//   Reset (aresetn low at a clock edge) empties the pipeline and clears the
//   mask. When m_ready is low the result holds; stages behind it keep
//   filling until all three are full, then s_ready drops. Nothing is lost or
//   repeated across a stall.
// ----------------------------------------------------------------------------
module tls_client_hello_sniffer
    import tchs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_hdr_byte_0,
    input  logic [7:0]  s_hdr_byte_1,
    input  logic [7:0]  s_hdr_byte_2,
    input  logic [7:0]  s_hdr_byte_3,
    input  logic [7:0]  s_hdr_byte_4,
    input  logic [7:0]  s_hdr_byte_5,
    input  logic [7:0]  s_hdr_byte_6,
    input  logic [7:0]  s_hdr_byte_7,
    input  logic [7:0]  s_hdr_byte_8,
    input  logic [7:0]  s_hdr_byte_9,
    input  logic [7:0]  s_hdr_byte_10,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic [1:0]  m_selected_version,
    output logic [7:0]  m_client_minor,
    output logic [14:0] m_body_length
);

    logic [4:0] disabled_versions_reg;
    hdr_bytes_t hdr;
    dec_t       dec_data;
    sel_t       sel_data;
    res_t       res_data;
    logic       dec_valid;
    logic       dec_ready;
    logic       sel_valid;
    logic       sel_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disabled_versions_reg <= 5'd0;
        end else if (cfg_wr_en) begin
            disabled_versions_reg <= cfg_wr_data;
        end
    end

    assign hdr = {s_hdr_byte_10, s_hdr_byte_9, s_hdr_byte_8, s_hdr_byte_7, s_hdr_byte_6,
                  s_hdr_byte_5, s_hdr_byte_4, s_hdr_byte_3, s_hdr_byte_2, s_hdr_byte_1,
                  s_hdr_byte_0};

    tchs_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_bytes  (hdr),
        .in_mask   (disabled_versions_reg),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    tchs_select u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (sel_valid),
        .out_ready (sel_ready),
        .out_data  (sel_data)
    );

    tchs_verdict u_verdict (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .in_data   (sel_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_data)
    );

    assign m_verdict          = res_data.verdict;
    assign m_selected_version = res_data.ver;
    assign m_client_minor     = res_data.minor;
    assign m_body_length      = res_data.blen;

endmodule

@@ hw/rtl/tchs_decode.sv @@
// ----------------------------------------------------------------------------
// tchs_decode
// First stage: find the header kind, effective client minor and v2 length.
// ----------------------------------------------------------------------------
module tchs_decode
    import tchs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  hdr_bytes_t in_bytes,
    input  logic [4:0] in_mask,
    output logic       out_valid,
    input  logic       out_ready,
    output dec_t       out_data
);

    logic valid_reg;
    dec_t data_reg;
    dec_t data_next;
    logic is_v2;
    logic is_rec;

    always_comb begin
        is_v2  = in_bytes[0][7] && in_bytes[2] == 8'd1;
        is_rec = in_bytes[0] == REC_HANDSHAKE && in_bytes[1] == 8'd3 && in_bytes[5] == 8'd1
                 && ((in_bytes[3] == 8'd0 && in_bytes[4] < 8'd5) || in_bytes[9] >= in_bytes[1]);

        data_next.kind  = KIND_UNKNOWN;
        data_next.minor = 8'd0;
        data_next.blen  = 15'd0;
        data_next.mask  = in_mask;

        if (is_v2) begin
            data_next.blen = {in_bytes[0][6:0], in_bytes[1]};
            if (in_bytes[3] == 8'd0 && in_bytes[4] == 8'd2) begin
                data_next.kind  = KIND_V2_ONLY;
                data_next.minor = in_bytes[4];
            end else if (in_bytes[3] == 8'd3) begin
                data_next.kind  = KIND_V2_WRAP;
                data_next.minor = in_bytes[4];
            end
        end else if (is_rec) begin
            data_next.kind = KIND_RECORD;
            // short fragment reads as TLS1.0, future majors as the top minor
            if (in_bytes[3] == 8'd0 && in_bytes[4] < 8'd6) begin
                data_next.minor = 8'd1;
            end else if (in_bytes[9] > 8'd3) begin
                data_next.minor = MINOR_MAX;
            end else begin
                data_next.minor = in_bytes[10];
            end
        end else if ({in_bytes[0], in_bytes[1], in_bytes[2], in_bytes[3]} == TXT_GET
                  || {in_bytes[0], in_bytes[1], in_bytes[2], in_bytes[3], in_bytes[4]} == TXT_POST
                  || {in_bytes[0], in_bytes[1], in_bytes[2], in_bytes[3], in_bytes[4]} == TXT_HEAD
                  || {in_bytes[0], in_bytes[1], in_bytes[2], in_bytes[3]} == TXT_PUT) begin
            data_next.kind = KIND_HTTP;
        end else if ({in_bytes[0], in_bytes[1], in_bytes[2], in_bytes[3],
                      in_bytes[4], in_bytes[5], in_bytes[6]} == TXT_CONN) begin
            data_next.kind = KIND_PROXY;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ hw/rtl/tchs_select.sv @@
// ----------------------------------------------------------------------------
// tchs_select
// Second stage: pick the highest allowed version and check the v2 length.
// ----------------------------------------------------------------------------
module tchs_select
    import tchs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  dec_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output sel_t out_data
);

    logic       valid_reg;
    sel_t       data_reg;
    sel_t       data_next;
    logic [2:0] pick;

    always_comb begin
        pick = pick_tls(in_data.minor, in_data.mask);

        data_next.kind      = in_data.kind;
        data_next.minor     = in_data.minor;
        data_next.blen      = in_data.blen;
        data_next.v2_off    = in_data.mask[MSK_V2];
        data_next.too_large = in_data.blen > V2_LIMIT;
        data_next.got       = 1'b0;
        data_next.ver       = VER_S30;

        if (in_data.minor != 8'd0) begin
            data_next.got = pick[2];
            data_next.ver = pick[1:0];
        end else if (!in_data.mask[MSK_V3]) begin
            data_next.got = 1'b1;
            data_next.ver = VER_S30;
        end else if (in_data.kind == KIND_RECORD && !in_data.mask[MSK_T10]) begin
            // record hello asking for SSL3.0 falls back to TLS1.0
            data_next.got = 1'b1;
            data_next.ver = VER_T10;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ hw/rtl/tchs_verdict.sv @@
// ----------------------------------------------------------------------------
// tchs_verdict
// Third stage: form the verdict and hold the result item for the receiver.
// ----------------------------------------------------------------------------
module tchs_verdict
    import tchs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sel_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic valid_reg;
    res_t data_reg;
    res_t data_next;

    always_comb begin
        data_next.verdict = VERDICT_UNKNOWN;
        data_next.ver     = VER_S30;
        data_next.minor   = in_data.minor;
        data_next.blen    = in_data.blen;
        case (in_data.kind)
            KIND_V2_ONLY: begin
                data_next.verdict = in_data.v2_off ? VERDICT_UNKNOWN : VERDICT_UNSUPPORTED;
            end
            KIND_V2_WRAP: begin
                if (in_data.got) begin
                    data_next.ver     = in_data.ver;
                    data_next.verdict = in_data.too_large ? VERDICT_TOO_LARGE
                                                          : VERDICT_V2_HELLO;
                end else begin
                    data_next.verdict = in_data.v2_off ? VERDICT_UNKNOWN
                                                       : VERDICT_UNSUPPORTED;
                end
            end
            KIND_RECORD: begin
                if (in_data.got) begin
                    data_next.ver     = in_data.ver;
                    data_next.verdict = VERDICT_RECORD;
                end
            end
            KIND_HTTP: begin
                data_next.verdict = VERDICT_HTTP;
            end
            KIND_PROXY: begin
                data_next.verdict = VERDICT_PROXY;
            end
            default: begin
                data_next.verdict = VERDICT_UNKNOWN;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ bench/tchs_checker.sv @@
// ----------------------------------------------------------------------------
// tchs_checker
// Watches both channels and the mask port of the client hello sniffer,
// classifies every accepted header on its own and compares each result,
// field by field and in order, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tchs_checker
    import tchs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  hdr_bytes_t  s_hdr,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_verdict,
    input  logic [1:0]  m_selected_version,
    input  logic [7:0]  m_client_minor,
    input  logic [14:0] m_body_length,
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);

    res_t       pending_verdicts[$];
    logic [4:0] off_mask;

    // Highest version the client minor reaches that the mask leaves open.
    function automatic logic highest_allowed(input logic [7:0] minor, input logic [4:0] off,
                                             output logic [1:0] ver);
        ver = VER_S30;
        if (minor >= 8'd3 && !off[MSK_T12]) begin
            ver = VER_T12;
        end else if (minor >= 8'd2 && !off[MSK_T11]) begin
            ver = VER_T11;
        end else if (!off[MSK_T10]) begin
            ver = VER_T10;
        end else if (off[MSK_V3]) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic res_t classify_header(input hdr_bytes_t h, input logic [4:0] off);
        res_t       r;
        logic       found;
        logic [1:0] v;
        r = '0;
        r.verdict = VERDICT_UNKNOWN;
        found = 1'b0;
        v = VER_S30;
        if (h[0][7] && h[2] == 8'd1) begin
            r.blen = {h[0][6:0], h[1]};
            if (h[3] == 8'd0 && h[4] == 8'd2) begin
                r.minor = h[4];
                r.verdict = off[MSK_V2] ? VERDICT_UNKNOWN : VERDICT_UNSUPPORTED;
            end else if (h[3] == 8'd3) begin
                r.minor = h[4];
                if (h[4] != 8'd0) begin
                    found = highest_allowed(h[4], off, v);
                end else begin
                    found = !off[MSK_V3];
                end
                if (found) begin
                    r.ver = v;
                    r.verdict = (r.blen > V2_LIMIT) ? VERDICT_TOO_LARGE : VERDICT_V2_HELLO;
                end else begin
                    r.verdict = off[MSK_V2] ? VERDICT_UNKNOWN : VERDICT_UNSUPPORTED;
                end
            end
        end else if (h[0] == REC_HANDSHAKE && h[1] == 8'd3 && h[5] == 8'd1 &&
                     ((h[3] == 8'd0 && h[4] < 8'd5) || h[9] >= h[1])) begin
            // short fragment reads as TLS1.0, a major above 3 as the top minor
            if (h[3] == 8'd0 && h[4] < 8'd6) begin
                r.minor = 8'd1;
            end else if (h[9] > 8'd3) begin
                r.minor = MINOR_MAX;
            end else begin
                r.minor = h[10];
            end
            if (r.minor != 8'd0) begin
                found = highest_allowed(r.minor, off, v);
            end else if (!off[MSK_V3]) begin
                found = 1'b1;
                v = VER_S30;
            end else if (!off[MSK_T10]) begin
                found = 1'b1;
                v = VER_T10;
            end
            if (found) begin
                r.verdict = VERDICT_RECORD;
                r.ver = v;
            end
        end else if ({h[0], h[1], h[2], h[3]} == TXT_GET ||
                     {h[0], h[1], h[2], h[3], h[4]} == TXT_POST ||
                     {h[0], h[1], h[2], h[3], h[4]} == TXT_HEAD ||
                     {h[0], h[1], h[2], h[3]} == TXT_PUT) begin
            r.verdict = VERDICT_HTTP;
        end else if ({h[0], h[1], h[2], h[3], h[4], h[5], h[6]} == TXT_CONN) begin
            r.verdict = VERDICT_PROXY;
        end
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            pending_verdicts.delete();
            off_mask = '0;
            fail_count = 0;
            checked_count = 0;
        end else begin
            // compare before push so a same-cycle result is never matched
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing outstanding: verdict %0d", $time,
                             m_verdict);
                end else begin
                    want = pending_verdicts.pop_front();
                    checked_count++;
                    check_field("verdict", want.verdict, m_verdict);
                    check_field("selected_version", want.ver, m_selected_version);
                    check_field("client_minor", want.minor, m_client_minor);
                    check_field("body_length", want.blen, m_body_length);
                end
            end
            if (s_valid && s_ready) begin
                pending_verdicts.push_back(classify_header(s_hdr, off_mask));
            end
            if (cfg_wr_en) begin
                off_mask = cfg_wr_data;
            end
        end
        pending_count <= pending_verdicts.size();
    end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives the client hello sniffer with directed headers for every verdict
// and corner, then with mostly well-formed random hellos and requests under
// several disable masks, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import tchs_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 106;

    localparam logic [87:0] HELLO_TLS12  = 88'h16_03_01_00_c8_01_00_00_c4_03_03;
    localparam logic [87:0] HELLO_SSL3   = 88'h16_03_00_00_60_01_00_00_5c_03_00;
    localparam logic [87:0] V2_ONLY      = 88'h80_2e_01_00_02_00_15_00_00_00_10;
    localparam logic [87:0] V2_WRAP_T12  = 88'h80_40_01_03_03_00_18_00_00_00_20;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    hdr_bytes_t  hdr;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [2:0]  m_verdict;
    logic [1:0]  m_selected_version;
    logic [7:0]  m_client_minor;
    logic [14:0] m_body_length;

    int fail_count;
    int pending_count;
    int checked_count;
    int tx_burst_left;
    int rx_burst_left;
    int rx_hold;
    int headers_sent;
    int mask_writes;
    logic [4:0] cur_mask;

    tls_client_hello_sniffer DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_hdr_byte_0       (hdr[0]),
        .s_hdr_byte_1       (hdr[1]),
        .s_hdr_byte_2       (hdr[2]),
        .s_hdr_byte_3       (hdr[3]),
        .s_hdr_byte_4       (hdr[4]),
        .s_hdr_byte_5       (hdr[5]),
        .s_hdr_byte_6       (hdr[6]),
        .s_hdr_byte_7       (hdr[7]),
        .s_hdr_byte_8       (hdr[8]),
        .s_hdr_byte_9       (hdr[9]),
        .s_hdr_byte_10      (hdr[10]),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_verdict          (m_verdict),
        .m_selected_version (m_selected_version),
        .m_client_minor     (m_client_minor),
        .m_body_length      (m_body_length)
    );

    tchs_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_hdr              (hdr),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_verdict          (m_verdict),
        .m_selected_version (m_selected_version),
        .m_client_minor     (m_client_minor),
        .m_body_length      (m_body_length),
        .fail_count         (fail_count),
        .pending_count      (pending_count),
        .checked_count      (checked_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Byte 0 sits in the top byte of the literal.
    function automatic hdr_bytes_t hdr_of(input logic [87:0] v);
        hdr_bytes_t h;
        for (int k = 0; k < NUM_BYTES; k++) begin
            h[k] = v[87 - 8 * k -: 8];
        end
        return h;
    endfunction

    function automatic hdr_bytes_t with_text(input hdr_bytes_t h, input logic [55:0] txt,
                                             input int n);
        for (int k = 0; k < n; k++) begin
            h[k] = txt[8 * (n - 1 - k) +: 8];
        end
        return h;
    endfunction

    function automatic hdr_bytes_t random_header();
        hdr_bytes_t  h;
        int          pick;
        logic [14:0] blen;
        for (int k = 0; k < NUM_BYTES; k++) begin
            h[k] = 8'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 32) begin
            h[0] = REC_HANDSHAKE;
            h[1] = 8'd3;
            h[5] = 8'd1;
            if ($urandom_range(0, 2) == 0) h[3] = 8'd0;
            if ($urandom_range(0, 1) == 0) h[4] = 8'($urandom_range(0, 7));
            case ($urandom_range(0, 5))
                0: h[9] = 8'd2;
                1, 2, 3: h[9] = 8'd3;
                4: h[9] = 8'($urandom_range(4, 255));
                default: ;
            endcase
            if ($urandom_range(0, 3) != 0) h[10] = 8'($urandom_range(0, 4));
            // break the record framing now and then
            if ($urandom_range(0, 9) == 0) h[$urandom_range(0, 5)] ^= 8'(1 << $urandom_range(0, 7));
        end else if (pick < 58) begin
            case ($urandom_range(0, 3))
                0: blen = 15'($urandom_range(4090, 4102));
                1: blen = 15'($urandom_range(0, 300));
                default: blen = 15'($urandom);
            endcase
            h[0] = {1'b1, blen[14:8]};
            h[1] = blen[7:0];
            if ($urandom_range(0, 9) != 0) h[2] = 8'd1;
            case ($urandom_range(0, 5))
                0: begin
                    h[3] = 8'd0;
                    h[4] = 8'd2;
                end
                1, 2, 3: begin
                    h[3] = 8'd3;
                    h[4] = 8'($urandom_range(0, 4));
                end
                4: h[3] = 8'd3;
                default: h[3] = 8'($urandom_range(0, 4));
            endcase
        end else if (pick < 74) begin
            case ($urandom_range(0, 3))
                0: h = with_text(h, TXT_GET, 4);
                1: h = with_text(h, TXT_POST, 5);
                2: h = with_text(h, TXT_HEAD, 5);
                default: h = with_text(h, TXT_PUT, 4);
            endcase
            if ($urandom_range(0, 6) == 0) h[$urandom_range(0, 4)] ^= 8'(1 << $urandom_range(0, 7));
        end else if (pick < 84) begin
            h = with_text(h, TXT_CONN, 7);
            if ($urandom_range(0, 6) == 0) h[$urandom_range(0, 6)] ^= 8'(1 << $urandom_range(0, 7));
        end
        return h;
    endfunction

    // Drain every outstanding result, let the pipe settle, then write the mask.
    task automatic set_mask(input logic [4:0] m);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_mask = m;
        mask_writes++;
    endtask

    task automatic send_header(input hdr_bytes_t h);
        int gap;
        if (tx_burst_left > 0) begin
            tx_burst_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 29) == 0) tx_burst_left = 40;
            gap = $urandom_range(0, 12);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        hdr <= h;
        do @(posedge aclk); while (s_ready !== 1'b1);
        headers_sent++;
    endtask

    task automatic directed(input logic [4:0] m, input logic [87:0] v);
        if (mask_writes == 0 || m != cur_mask) set_mask(m);
        send_header(hdr_of(v));
    endtask

    // Result side: after each accepted item, hold ready low for a drawn stall.
    always @(posedge aclk) begin : rx_side
        int stall;
        if (!aresetn) begin
            m_ready <= 1'b1;
            rx_hold <= 0;
            rx_burst_left = 0;
        end else if (m_valid && m_ready) begin
            if (rx_burst_left > 0) begin
                rx_burst_left--;
                stall = 0;
            end else begin
                if ($urandom_range(0, 29) == 0) rx_burst_left = 40;
                stall = $urandom_range(0, 12);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                rx_hold <= stall;
            end
        end else if (!m_ready) begin
            if (rx_hold <= 1) m_ready <= 1'b1;
            rx_hold <= rx_hold - 1;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("FAIL tls_client_hello_sniffer");
        $finish;
    end

    initial begin : stimulus
        logic [4:0] phase_masks [RANDOM_PHASES];
        int         directed_sent;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        hdr <= '0;
        tx_burst_left = 0;
        headers_sent = 0;
        mask_writes = 0;
        cur_mask = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // all versions open
        directed(5'h00, 88'h0);
        directed(5'h00, {11{8'hff}});
        directed(5'h00, HELLO_TLS12);
        directed(5'h00, 88'h16_03_01_00_04_01_00_00_00_02_00);  // short fragment
        directed(5'h00, 88'h16_03_01_00_05_01_00_00_01_03_00);  // short fragment via major
        directed(5'h00, 88'h16_03_01_01_00_01_00_00_fc_04_00);  // major above 3
        directed(5'h00, HELLO_SSL3);
        directed(5'h00, V2_ONLY);
        directed(5'h00, V2_WRAP_T12);
        directed(5'h00, 88'h90_01_01_03_01_00_18_00_00_00_20);  // one past the body limit
        directed(5'h00, 88'h90_00_01_03_01_00_18_00_00_00_20);  // exactly at the limit
        directed(5'h00, 88'hff_ff_01_03_00_00_18_00_00_00_20);  // largest body
        directed(5'h00, 88'h80_40_01_02_00_00_18_00_00_00_20);  // v2 framing, odd major
        directed(5'h00, "GET /index.");
        directed(5'h00, "POST /a HTT");
        directed(5'h00, "HEAD / HTTP");
        directed(5'h00, "PUT /x HTTP");
        directed(5'h00, "CONNECT a:4");
        directed(5'h00, "GETX /index");
        // SSLv2 off
        directed(5'h01, V2_ONLY);
        // SSLv3 off: fall back to TLS1.0, wrapped SSL3 hello has nothing
        directed(5'h02, HELLO_SSL3);
        directed(5'h02, 88'h80_40_01_03_00_00_18_00_00_00_20);
        // only SSLv2 left
        directed(5'h1e, HELLO_TLS12);
        directed(5'h1e, V2_WRAP_T12);
        // everything off
        directed(5'h1f, V2_WRAP_T12);
        directed_sent = headers_sent;

        phase_masks = '{5'h00, 5'h1f, 5'h01, 5'h02, 5'h1e, 5'h18, 5'($urandom), 5'($urandom)};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_mask(phase_masks[p]);
            repeat (ITEMS_PER_PHASE) send_header(random_header());
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d headers (%0d directed) under %0d mask settings.",
                 headers_sent, directed_sent, mask_writes);
        $display("Checker compared %0d results, %0d mismatches.", checked_count, fail_count);
        if (fail_count == 0) begin
            $display("PASS tls_client_hello_sniffer");
        end else begin
            $display("FAIL tls_client_hello_sniffer");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tchs_pkg.sv
hw/rtl/tchs_decode.sv
hw/rtl/tchs_select.sv
hw/rtl/tchs_verdict.sv
hw/rtl/tls_client_hello_sniffer.sv
bench/tchs_checker.sv
bench/tb.sv
